>>> design/art_pkg.sv
// Shared types, codes and defaults for the acknowledgment retransmit tracker.
// Used by art_slot_eval and ack_retransmit_tracker_unit; depends on nothing else.
package art_pkg;

   // Default table geometry.
   localparam int NUM_DEST_DEF       = 4;
   localparam int SLOTS_PER_DEST_DEF = 8;

   // Configuration register reset values.
   localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd100;
   localparam logic [7:0]  MAX_TRIALS_RESET  = 8'd3;

   // Configuration register indexes.
   localparam logic CSR_ACK_TIMEOUT = 1'b0;
   localparam logic CSR_MAX_TRIALS  = 1'b1;

   // Command codes of an input word.
   localparam logic [1:0] CMD_TRACK = 2'd0;
   localparam logic [1:0] CMD_ACK   = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_TRACKED   = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_ACK       = 3'd2;
   localparam logic [2:0] KIND_RESEND    = 3'd3;
   localparam logic [2:0] KIND_DROPPED   = 3'd4;
   localparam logic [2:0] KIND_TICK_DONE = 3'd5;

   // One table entry as kept in the slot memory.
   typedef struct packed {
      logic [15:0] id;
      logic [31:0] stamp;
      logic [7:0]  trials;
   } slot_type;

   // Verdict of the slot evaluator for the entry under inspection.
   typedef struct packed {
      logic       hit;
      logic       drop;
      logic [7:0] trials_next;
   } eval_type;

endpackage

>>> design/art_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/art_slot_eval.sv
// Shared per-entry evaluator: id match, free test, wrapping timeout compare and
// trial count update for the one table entry that the sequencer has fetched. Uses art_pkg.
module art_slot_eval (
   input  logic [1:0]        command,
   input  logic              slot_valid,
   input  art_pkg::slot_type slot,
   input  logic [15:0]       message_id,
   input  logic [31:0]       now_ms,
   input  logic [15:0]       ack_timeout,
   input  logic [7:0]        max_trials,
   output art_pkg::eval_type verdict
);

   logic [31:0] elapsed;
   logic        timed_out;
   logic [8:0]  trials_inc;

   // Wrapping elapsed time since the entry was last sent.
   assign elapsed    = now_ms - slot.stamp;
   assign timed_out  = elapsed >= {16'd0, ack_timeout};
   assign trials_inc = {1'b0, slot.trials} + 9'd1;

   // The meaning of a hit depends on the command being worked.
   always_comb begin
      verdict.drop        = trials_inc > {1'b0, max_trials};
      verdict.trials_next = trials_inc[8] ? 8'hFF : trials_inc[7:0];
      case (command)
         art_pkg::CMD_TRACK: verdict.hit = !slot_valid;
         art_pkg::CMD_ACK:   verdict.hit = slot_valid && (slot.id == message_id);
         art_pkg::CMD_TICK:  verdict.hit = slot_valid && timed_out;
         default:            verdict.hit = 1'b0;
      endcase
   end

endmodule

>>> design/ack_retransmit_tracker_unit.sv
// Acknowledgment retransmit tracker: a per-destination table of messages that wait
// for an acknowledgment. Uses art_pkg, art_ram and art_slot_eval.
//
// A word is taken only while the sequencer is idle, and the table is walked entry by
// entry (S_READ, then S_CHECK) through the single read port of the slot memory and one
// shared evaluator. A track or ack walks the destination's entries (a track stops at
// the first free slot), a tick walks the whole table; the walk stalls while the result
// side holds off a pending result. Command 3 is taken and dropped with no result.
// A finished result sits in an output register, so the next word can be taken
// while it waits. Valid bits live in flip-flops cleared by reset; no clearing pass.
module ack_retransmit_tracker_unit #(
   parameter int NUM_DEST       = art_pkg::NUM_DEST_DEF,
   parameter int SLOTS_PER_DEST = art_pkg::SLOTS_PER_DEST_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input words.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [1:0]  req_destination,
   input  logic [15:0] req_message_id,
   input  logic [31:0] req_timestamp_ms,
   // Result words.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_dest_out,
   output logic [15:0] rsp_id_out,
   output logic [7:0]  rsp_trials_out,
   output logic [3:0]  rsp_cleared_count,
   output logic        rsp_last,
   // Configuration writes.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int NUM_SLOTS = NUM_DEST * SLOTS_PER_DEST;
   localparam int IDX_W     = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
   localparam int SUB_W     = SLOTS_PER_DEST > 1 ? $clog2(SLOTS_PER_DEST) : 1;
   localparam int DEST_W    = NUM_DEST > 1 ? $clog2(NUM_DEST) : 1;
   localparam int SLOT_BITS = $bits(art_pkg::slot_type);

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_FINAL = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [SUB_W-1:0]     sub_ff, sub_in;
   logic [DEST_W-1:0]    dcnt_ff, dcnt_in;
   logic [3:0]           cleared_ff, cleared_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [15:0]          timeout_ff;
   logic [7:0]           max_trials_ff;

   logic [1:0]  cmd_ff;
   logic [1:0]  dest_ff;
   logic [15:0] id_ff;
   logic [31:0] now_ff;

   logic        rsp_valid_ff;
   logic [2:0]  kind_ff, kind_in;
   logic [1:0]  dest_out_ff, dest_out_in;
   logic [15:0] id_out_ff, id_out_in;
   logic [7:0]  trials_out_ff, trials_out_in;
   logic [3:0]  count_out_ff, count_out_in;
   logic        last_ff, last_in;

   logic                 accept;
   logic                 dest_ok;
   logic                 out_free;
   logic                 emit;
   logic                 last_slot;
   logic                 need_emit;
   logic                 ram_we;
   art_pkg::slot_type    ram_wdata;
   logic [SLOT_BITS-1:0] ram_rdata;
   art_pkg::slot_type    slot_rd;
   art_pkg::eval_type    verdict;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign dest_ok   = 32'(req_destination) < NUM_DEST;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign slot_rd   = art_pkg::slot_type'(ram_rdata);

   // Entry storage: id, send time and trial count.
   art_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // Shared evaluator for the entry currently read.
   art_slot_eval u_eval (
      .command     (cmd_ff),
      .slot_valid  (valid_ff[idx_ff]),
      .slot        (slot_rd),
      .message_id  (id_ff),
      .now_ms      (now_ff),
      .ack_timeout (timeout_ff),
      .max_trials  (max_trials_ff),
      .verdict     (verdict)
   );

   assign last_slot = (sub_ff == SUB_W'(SLOTS_PER_DEST - 1)) &&
                      ((cmd_ff != art_pkg::CMD_TICK) || (dcnt_ff == DEST_W'(NUM_DEST - 1)));
   assign need_emit = verdict.hit &&
                      ((cmd_ff == art_pkg::CMD_TRACK) || (cmd_ff == art_pkg::CMD_TICK));

   // Sequencer: walk the entries, update the table and produce result words.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      sub_in        = sub_ff;
      dcnt_in       = dcnt_ff;
      cleared_in    = cleared_ff;
      valid_in      = valid_ff;
      ram_we        = 1'b0;
      ram_wdata     = slot_rd;
      emit          = 1'b0;
      kind_in       = art_pkg::KIND_TICK_DONE;
      dest_out_in   = 2'd0;
      id_out_in     = 16'd0;
      trials_out_in = 8'd0;
      count_out_in  = 4'd0;
      last_in       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sub_in     = '0;
               cleared_in = 4'd0;
               if (req_command == art_pkg::CMD_TICK) begin
                  idx_in   = '0;
                  dcnt_in  = '0;
                  state_in = S_READ;
               end else if (req_command == art_pkg::CMD_TRACK ||
                            req_command == art_pkg::CMD_ACK) begin
                  idx_in   = IDX_W'(32'(req_destination) * SLOTS_PER_DEST);
                  dcnt_in  = DEST_W'(req_destination);
                  state_in = dest_ok ? S_READ : S_FINAL;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!need_emit || out_free) begin
               if (verdict.hit) begin
                  case (cmd_ff)
                     art_pkg::CMD_TRACK: begin
                        valid_in[idx_ff] = 1'b1;
                        ram_we           = 1'b1;
                        ram_wdata.id     = id_ff;
                        ram_wdata.stamp  = now_ff;
                        ram_wdata.trials = 8'd1;
                        emit             = 1'b1;
                        kind_in          = art_pkg::KIND_TRACKED;
                        dest_out_in      = dest_ff;
                        id_out_in        = id_ff;
                        trials_out_in    = 8'd1;
                     end
                     art_pkg::CMD_ACK: begin
                        valid_in[idx_ff] = 1'b0;
                        cleared_in       = cleared_ff + 4'd1;
                     end
                     default: begin
                        // Timed-out entry on a tick: restamp, then resend or drop.
                        ram_we           = 1'b1;
                        ram_wdata.stamp  = now_ff;
                        ram_wdata.trials = verdict.trials_next;
                        if (verdict.drop) begin
                           valid_in[idx_ff] = 1'b0;
                        end
                        emit          = 1'b1;
                        kind_in       = verdict.drop ? art_pkg::KIND_DROPPED
                                                     : art_pkg::KIND_RESEND;
                        dest_out_in   = 2'(dcnt_ff);
                        id_out_in     = slot_rd.id;
                        trials_out_in = verdict.trials_next;
                        last_in       = 1'b0;
                     end
                  endcase
               end
               if (verdict.hit && cmd_ff == art_pkg::CMD_TRACK) begin
                  state_in = S_IDLE;
               end else if (last_slot) begin
                  state_in = S_FINAL;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_READ;
                  if (sub_ff == SUB_W'(SLOTS_PER_DEST - 1)) begin
                     sub_in  = '0;
                     dcnt_in = dcnt_ff + DEST_W'(1);
                  end else begin
                     sub_in = sub_ff + SUB_W'(1);
                  end
               end
            end
         end
         default: begin
            // Closing word of the command.
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               case (cmd_ff)
                  art_pkg::CMD_TRACK: begin
                     kind_in     = art_pkg::KIND_FULL;
                     dest_out_in = dest_ff;
                     id_out_in   = id_ff;
                  end
                  art_pkg::CMD_ACK: begin
                     kind_in      = art_pkg::KIND_ACK;
                     dest_out_in  = dest_ff;
                     id_out_in    = id_ff;
                     count_out_in = cleared_ff;
                  end
                  default: begin
                     kind_in = art_pkg::KIND_TICK_DONE;
                  end
               endcase
            end
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         sub_ff        <= '0;
         dcnt_ff       <= '0;
         cleared_ff    <= 4'd0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         timeout_ff    <= art_pkg::ACK_TIMEOUT_RESET;
         max_trials_ff <= art_pkg::MAX_TRIALS_RESET;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         sub_ff     <= sub_in;
         dcnt_ff    <= dcnt_in;
         cleared_ff <= cleared_in;
         valid_ff   <= valid_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               art_pkg::CSR_ACK_TIMEOUT: timeout_ff    <= csr_wdata;
               art_pkg::CSR_MAX_TRIALS:  max_trials_ff <= csr_wdata[7:0];
               default:                  timeout_ff    <= timeout_ff;
            endcase
         end
      end
   end

   // Captured input word and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         dest_ff <= req_destination;
         id_ff   <= req_message_id;
         now_ff  <= req_timestamp_ms;
      end
      if (emit) begin
         kind_ff       <= kind_in;
         dest_out_ff   <= dest_out_in;
         id_out_ff     <= id_out_in;
         trials_out_ff <= trials_out_in;
         count_out_ff  <= count_out_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_dest_out      = dest_out_ff;
   assign rsp_id_out        = id_out_ff;
   assign rsp_trials_out    = trials_out_ff;
   assign rsp_cleared_count = count_out_ff;
   assign rsp_last          = last_ff;

   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result word overwritten while pending");

   // The closing word of a command returns the sequencer to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && last_in) |=> (state_ff == S_IDLE))
      else $error("sequencer busy after closing word");

   // An ack never clears more entries than one destination owns.
   a_cleared_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(cleared_ff) <= SLOTS_PER_DEST))
      else $error("cleared count beyond slots per destination");

   // The walk index stays inside the table.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_CHECK) |-> (32'(idx_ff) < NUM_SLOTS))
      else $error("slot index out of range");

endmodule
